// ===== design/xmodem_crc_receiver_assert.svh =====
// assertion macros for the xmodem crc receiver
// used by the receiver core; no other dependencies
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, disabled while reset is asserted
`define XMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define XMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define XMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define XMC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/xmc_pkg.sv =====
// shared types, constants and crc function for the xmodem crc receiver
// no dependencies
`default_nettype none

package xmc_pkg;

    // packet geometry and storage sizing
    localparam int PAYLOAD_BYTES = 128;
    localparam int PAGE_BYTES    = 4096;
    localparam int MAX_PAGES     = 65536;
    localparam int PKT_BYTES     = PAYLOAD_BYTES + 5;
    localparam int HDR_BYTES     = 3;
    localparam int CRC_HI_INDEX  = HDR_BYTES + PAYLOAD_BYTES;

    localparam int PAYLOAD_SHIFT = $clog2(PAYLOAD_BYTES);
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);

    localparam int INDEX_W  = 8;
    localparam int BLOCKS_W = 21;
    localparam int SIZE_W   = 28;
    localparam int OFFSET_W = 12;
    localparam int PAGE_W   = 16;

    localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);

    // block capacity, clamped to the counter range
    localparam longint CAP_RAW =
        (longint'(MAX_PAGES) * longint'(PAGE_BYTES)) / longint'(PAYLOAD_BYTES);
    localparam longint BLOCKS_MAX = (longint'(1) << BLOCKS_W) - 1;
    localparam logic [BLOCKS_W-1:0] CAP_BLOCKS =
        (CAP_RAW > BLOCKS_MAX) ? BLOCKS_W'(BLOCKS_MAX) : BLOCKS_W'(CAP_RAW);

    // protocol bytes
    localparam logic [7:0]  SOH_BYTE = 8'h01;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // reply to send back to the sender
    typedef enum logic [1:0] {
        RC_NONE = 2'd0,
        RC_ACK  = 2'd1,
        RC_NAK  = 2'd2,
        RC_C    = 2'd3
    } reply_t;

    // input transaction
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_item_t;

    // result transaction
    typedef struct packed {
        reply_t              reply_code;
        logic                write_valid;
        logic [OFFSET_W-1:0] write_offset;
        logic [7:0]          write_data;
        logic                page_ready;
        logic [PAGE_W-1:0]   page_number;
        logic                transfer_done;
        logic [SIZE_W-1:0]   total_bytes;
    } out_item_t;

    // bitwise crc-16 update for one byte, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== design/xmc_in_reg.sv =====
// input holding register for the xmodem crc receiver
// depends on xmc_pkg for the input transaction type
`default_nettype none

module xmc_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire xmc_pkg::in_item_t item,
    input  wire logic             advance,
    output logic                  hold_valid,
    output xmc_pkg::in_item_t     hold_item
);

    logic              valid_reg;
    logic              valid_next;
    xmc_pkg::in_item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign item_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

// ===== design/xmc_out_reg.sv =====
// result register for the xmodem crc receiver
// depends on xmc_pkg for the result transaction type
`default_nettype none

module xmc_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire xmc_pkg::out_item_t load_item,
    output logic                    space,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output xmc_pkg::out_item_t      result
);

    logic               valid_reg;
    logic               valid_next;
    xmc_pkg::out_item_t result_reg;

    // can take a new result when empty or draining this cycle
    assign space = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_item;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/xmc_core.sv =====
// packet state machine, crc check and page bookkeeping
// depends on xmc_pkg and xmodem_crc_receiver_assert.svh
`default_nettype none

`include "xmodem_crc_receiver_assert.svh"

module xmc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire xmc_pkg::in_item_t item,
    output xmc_pkg::out_item_t     step_result
);

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    localparam logic [xmc_pkg::INDEX_W-1:0] IDX_BLK    = xmc_pkg::INDEX_W'(1);
    localparam logic [xmc_pkg::INDEX_W-1:0] IDX_COMP   = xmc_pkg::INDEX_W'(2);
    localparam logic [xmc_pkg::INDEX_W-1:0] IDX_DATA   =
        xmc_pkg::INDEX_W'(xmc_pkg::HDR_BYTES);
    localparam logic [xmc_pkg::INDEX_W-1:0] IDX_CRC_HI =
        xmc_pkg::INDEX_W'(xmc_pkg::CRC_HI_INDEX);
    localparam logic [xmc_pkg::INDEX_W-1:0] IDX_LAST   =
        xmc_pkg::INDEX_W'(xmc_pkg::PKT_BYTES - 1);

    phase_t                          phase_reg,    phase_next;
    logic [xmc_pkg::INDEX_W-1:0]     index_reg,    index_next;
    logic [7:0]                      header_reg,   header_next;
    logic [7:0]                      blk_reg,      blk_next;
    logic [7:0]                      comp_reg,     comp_next;
    logic [15:0]                     crc_reg,      crc_next;
    logic [15:0]                     rxcrc_reg,    rxcrc_next;
    logic [7:0]                      expect_reg,   expect_next;
    logic [xmc_pkg::BLOCKS_W-1:0]    blocks_reg,   blocks_next;

    logic                            full;
    logic [xmc_pkg::SIZE_W-1:0]      filesize;
    logic [xmc_pkg::SIZE_W:0]        nsize;
    logic [xmc_pkg::SIZE_W-1:0]      wsum;
    logic                            pkt_good;
    xmc_pkg::out_item_t              res;

    // derived byte counts
    assign full     = blocks_reg >= xmc_pkg::CAP_BLOCKS;
    assign filesize = xmc_pkg::SIZE_W'(blocks_reg) << xmc_pkg::PAYLOAD_SHIFT;
    assign nsize    = (xmc_pkg::SIZE_W + 1)'(filesize) +
                      (xmc_pkg::SIZE_W + 1)'(xmc_pkg::PAYLOAD_BYTES);
    assign wsum     = (filesize + xmc_pkg::SIZE_W'(index_reg - IDX_DATA))
                      & xmc_pkg::PAGE_MASK;

    // header, crc and capacity checks against the values that the last byte leaves behind
    assign pkt_good = (header_reg == xmc_pkg::SOH_BYTE) &&
                      (blk_reg == expect_reg) &&
                      ((~comp_reg) == expect_reg) &&
                      (crc_reg == rxcrc_next) &&
                      !full;

    // one step of the receiver per transaction
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        header_next = header_reg;
        blk_next    = blk_reg;
        comp_next   = comp_reg;
        crc_next    = crc_reg;
        rxcrc_next  = rxcrc_reg;
        expect_next = expect_reg;
        blocks_next = blocks_reg;
        res         = '0;
        res.reply_code = xmc_pkg::RC_NONE;

        if (phase_reg == PH_DONE)
        begin
            res.transfer_done = 1'b1;
        end
        else if (item.command)
        begin
            if (phase_reg == PH_WAIT)
            begin
                res.reply_code = xmc_pkg::RC_C;
            end
            else if (index_reg != '0)
            begin
                // short packet
                res.reply_code = xmc_pkg::RC_NAK;
                index_next     = '0;
            end
            else
            begin
                // idle timeout ends the transfer
                phase_next        = PH_DONE;
                res.transfer_done = 1'b1;
                if ((filesize & xmc_pkg::PAGE_MASK) != '0)
                begin
                    res.page_ready  = 1'b1;
                    res.page_number =
                        xmc_pkg::PAGE_W'(filesize >> xmc_pkg::PAGE_SHIFT);
                end
            end
        end
        else
        begin
            phase_next = PH_RECV;

            // store the byte by its place in the packet
            priority if (index_reg == '0)
            begin
                header_next = item.rx_byte;
                crc_next    = '0;
            end
            else if (index_reg == IDX_BLK)
            begin
                blk_next = item.rx_byte;
            end
            else if (index_reg == IDX_COMP)
            begin
                comp_next = item.rx_byte;
            end
            else if (index_reg < IDX_CRC_HI)
            begin
                crc_next = xmc_pkg::crc_step(crc_reg, item.rx_byte);
                if (!full)
                begin
                    res.write_valid  = 1'b1;
                    res.write_offset = wsum[xmc_pkg::OFFSET_W-1:0];
                    res.write_data   = item.rx_byte;
                end
            end
            else if (index_reg == IDX_CRC_HI)
            begin
                rxcrc_next = {item.rx_byte, 8'h00};
            end
            else
            begin
                rxcrc_next = {rxcrc_reg[15:8], item.rx_byte};
            end

            // end of packet verdict
            if (index_reg >= IDX_LAST)
            begin
                index_next = '0;
                if (pkt_good)
                begin
                    res.reply_code = xmc_pkg::RC_ACK;
                    blocks_next    = blocks_reg + 1'b1;
                    expect_next    = expect_reg + 8'd1;
                    if ((nsize >> xmc_pkg::PAGE_SHIFT) !=
                        ((xmc_pkg::SIZE_W + 1)'(filesize) >> xmc_pkg::PAGE_SHIFT))
                    begin
                        res.page_ready  = 1'b1;
                        res.page_number =
                            xmc_pkg::PAGE_W'(filesize >> xmc_pkg::PAGE_SHIFT);
                    end
                end
                else
                begin
                    res.reply_code = xmc_pkg::RC_NAK;
                end
            end
            else
            begin
                index_next = index_reg + 1'b1;
            end
        end

        res.total_bytes = xmc_pkg::SIZE_W'(blocks_next) << xmc_pkg::PAYLOAD_SHIFT;
    end

    assign step_result = res;

    // receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            index_reg  <= '0;
            header_reg <= '0;
            blk_reg    <= '0;
            comp_reg   <= '0;
            crc_reg    <= '0;
            rxcrc_reg  <= '0;
            expect_reg <= 8'd1;
            blocks_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            header_reg <= header_next;
            blk_reg    <= blk_next;
            comp_reg   <= comp_next;
            crc_reg    <= crc_next;
            rxcrc_reg  <= rxcrc_next;
            expect_reg <= expect_next;
            blocks_reg <= blocks_next;
        end
    end

    `XMC_ASSERT_ALWAYS(a_index_in_packet, clk, index_reg <= IDX_LAST, "byte index past packet end")
    `XMC_ASSERT(a_done_sticks, clk, rst_n, phase_reg == PH_DONE |=> phase_reg == PH_DONE, "left done phase")
    `XMC_ASSERT(a_blocks_hold, clk, rst_n, !advance |=> $stable(blocks_reg), "block count moved without a transaction")
    `XMC_ASSERT(a_ack_counts, clk, rst_n, advance && res.reply_code == xmc_pkg::RC_ACK |=> blocks_reg == $past(blocks_reg) + 1'b1, "ack without block count step")

endmodule

`default_nettype wire

// ===== design/xmodem_crc_receiver.sv =====
// top level of the xmodem crc receiver: input register, core, result register
// depends on xmc_pkg, xmc_in_reg, xmc_core and xmc_out_reg
//
//   channel   direction   payload       handshake
//   item      in          in_item_t     item_valid / item_ready
//   result    out         out_item_t    result_valid / result_ready
//
// one result per transaction, one transaction per cycle sustained while result_ready stays high
// a transaction passes the input register, then the core step into the result register
// the core step (crc byte update and packet checks) sets the cycle
// rst_n clears the handshake flags and the receiver state, waiting for the first byte
// while the result waits, one more transaction is taken into the input register
`default_nettype none

module xmodem_crc_receiver (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire xmc_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output xmc_pkg::out_item_t      result
);

    logic               hold_valid;
    xmc_pkg::in_item_t  hold_item;
    logic               out_space;
    logic               advance;
    xmc_pkg::out_item_t step_result;

    // move the held transaction through the core when the result register has room
    assign advance = hold_valid && out_space;

    xmc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    xmc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (hold_item),
        .step_result (step_result)
    );

    xmc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .load_item    (step_result),
        .space        (out_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
